// ===== design/psg_pkg.sv =====
package psg_pkg;

    localparam int TONE_CHANNELS = 3;

    localparam int STEP_W  = 16;
    localparam int REG_W   = 10;
    localparam int GAIN_W  = 14;
    localparam int PER_W   = 27;
    localparam int LEFT_W  = 17;
    localparam int OPA_W   = 30;
    localparam int OPB_W   = 17;
    localparam int PROD_W  = OPA_W + OPB_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int LFSR_W  = 16;
    localparam int FB_W    = 17;
    localparam int Y_W     = 40;

    localparam logic [1:0] MODE_TONE  = 2'd0;
    localparam logic [1:0] MODE_NOISE = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    localparam logic CFG_UPDATE_STEP = 1'b0;
    localparam logic CFG_DC_POLE     = 1'b1;

    localparam logic [STEP_W-1:0] UPDATE_STEP_RST = 16'd15052;
    localparam logic [STEP_W-1:0] DC_POLE_RST     = 16'd65443;

    localparam logic [FB_W-1:0]   FB_WHITE    = 17'h14002;
    localparam logic [FB_W-1:0]   FB_PERIODIC = 17'h08000;
    localparam logic [LFSR_W-1:0] LFSR_PRESET = 16'h0f35;
    localparam logic [LEFT_W-1:0] ONE_STEP    = 17'h10000;

    function automatic logic [GAIN_W-1:0] vol_gain(input logic [3:0] v);
        logic [GAIN_W-1:0] g;
        case (v)
            4'd0:    g = 14'd10922;
            4'd1:    g = 14'd8675;
            4'd2:    g = 14'd6891;
            4'd3:    g = 14'd5473;
            4'd4:    g = 14'd4348;
            4'd5:    g = 14'd3453;
            4'd6:    g = 14'd2743;
            4'd7:    g = 14'd2179;
            4'd8:    g = 14'd1731;
            4'd9:    g = 14'd1374;
            4'd10:   g = 14'd1092;
            4'd11:   g = 14'd867;
            4'd12:   g = 14'd689;
            4'd13:   g = 14'd547;
            4'd14:   g = 14'd434;
            default: g = 14'd0;
        endcase
        return g;
    endfunction

    // clamp to [0, 0x7fff0000] and keep the integer part
    function automatic logic [14:0] clamp_sum(input logic signed [SUM_W-1:0] s);
        logic [14:0] r;
        if (s < 0) begin
            r = '0;
        end else if (s > $signed({{(SUM_W-32){1'b0}}, 32'h7fff0000})) begin
            r = 15'h7fff;
        end else begin
            r = s[30:16];
        end
        return r;
    endfunction

endpackage

// ===== design/psg_tone_noise_generator.sv =====
// Programmable sound generator: square-wave tone channels plus an LFSR noise
// channel, mixed and DC-blocked into one signed 16-bit sample per tick.
// Input channel (i_valid / o_stall, payload i_mode, i_data): mode 0 writes a
// tone-port byte, mode 1 a noise-port byte, mode 2 asks for one sample, mode 3
// is dropped. Output channel (o_valid / i_stall, payload o_sample) gives one
// beat per tick and nothing for writes.
// A register write is applied in the idle state and leaves the block idle. A
// tick runs on one shared divider (one quotient bit a cycle) and one shared
// registered multiplier: each tone channel is loaded, multiplied and
// accumulated, with a divide between load and multiply when the channel
// wraps; then come noise setup, the noise walk (one step per LFSR event inside
// the sample step plus the last partial step, none while the noise volume or
// the noise period is zero), mixing, the DC blocker and the output register;
// a new beat waits for all of it. Short noise periods make the walk dominate.
// o_stall is high while a tick is in progress. A finished sample waits in a
// holding register until the output register is free, with o_stall held high.
// Synchronous reset restores the state registers and the config values.
// Config writes (i_cfg_we, i_cfg_index, i_cfg_data) belong to idle periods.
module psg_tone_noise_generator #(
    parameter int TONE_CHANNELS = psg_pkg::TONE_CHANNELS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_mode,
    input  logic [7:0]                   i_data,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [15:0]           o_sample,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [psg_pkg::STEP_W-1:0]   i_cfg_data
);

    localparam int CH_W   = (TONE_CHANNELS > 1) ? $clog2(TONE_CHANNELS) : 1;
    localparam int PER_W  = psg_pkg::PER_W;
    localparam int LEFT_W = psg_pkg::LEFT_W;
    localparam int OPA_W  = psg_pkg::OPA_W;
    localparam int OPB_W  = psg_pkg::OPB_W;
    localparam int PROD_W = psg_pkg::PROD_W;
    localparam int SUM_W  = psg_pkg::SUM_W;
    localparam int Y_W    = psg_pkg::Y_W;

    typedef enum logic [3:0] {
        S_IDLE, S_T_LOAD, S_T_DIV, S_T_MUL, S_T_ACC, S_N_INIT, S_N_RUN,
        S_N_MUL, S_N_ACC, S_D_LO, S_D_HI, S_D_FIN, S_OUT
    } t_state;

    t_state r_state;

    logic [psg_pkg::STEP_W-1:0] r_step;
    logic [psg_pkg::STEP_W-1:0] r_pole;

    logic [psg_pkg::REG_W-1:0]  r_freq [2][3];
    logic [2:0]                 r_latch [2];
    logic [1:0]                 r_nmode;

    logic [PER_W-1:0]           r_tper  [TONE_CHANNELS];
    logic [PER_W-1:0]           r_tcnt  [TONE_CHANNELS];
    logic                       r_tlvl  [TONE_CHANNELS];
    logic [psg_pkg::GAIN_W-1:0] r_tgain [TONE_CHANNELS];

    logic [PER_W-1:0]           r_ntone2;
    logic [PER_W-1:0]           r_nper;
    logic [PER_W-1:0]           r_ncnt;
    logic [psg_pkg::LFSR_W-1:0] r_lfsr;
    logic [psg_pkg::FB_W-1:0]   r_fb;
    logic                       r_nlvl;
    logic [psg_pkg::GAIN_W-1:0] r_ngain;

    logic [15:0]                r_xprev;
    logic signed [Y_W-1:0]      r_yprev;

    logic [CH_W-1:0]            r_ch;
    logic [LEFT_W-1:0]          r_negc;
    logic signed [OPA_W-1:0]    r_val;
    logic signed [SUM_W-1:0]    r_sum;
    logic [14:0]                r_tone_x;
    logic [15:0]                r_x;
    logic [LEFT_W-1:0]          r_left;
    logic [LEFT_W-1:0]          r_vol;
    logic signed [PROD_W-1:0]   r_plo;

    logic                       r_valid;
    logic signed [15:0]         r_sample;
    logic [15:0]                r_hold;

    // ---------------- register writes ----------------
    logic                       in_acc;
    logic                       wr_port;
    logic                       wr_latch;
    logic [2:0]                 wr_r;
    logic                       wr_is_freq;
    logic [1:0]                 wr_fi;
    logic [psg_pkg::REG_W-1:0]  wr_old;
    logic [psg_pkg::REG_W-1:0]  wr_new;
    logic [25:0]                wr_prod;
    logic [PER_W-1:0]           wr_per;
    logic [PER_W-1:0]           nm_per;

    assign in_acc     = i_valid && !o_stall;
    assign wr_port    = i_mode[0];
    assign wr_latch   = i_data[7];
    assign wr_r       = wr_latch ? i_data[6:4] : r_latch[wr_port];
    assign wr_is_freq = !wr_r[0] && (wr_r != 3'd6);
    assign wr_fi      = wr_r[2:1];
    assign wr_old     = r_freq[wr_port][(wr_fi == 2'd3) ? 2'd0 : wr_fi];
    assign wr_new     = wr_latch ? {wr_old[9:4], i_data[3:0]}
                                 : {i_data[5:0], wr_old[3:0]};
    assign wr_prod    = r_step * wr_new;
    assign wr_per     = (wr_prod == '0) ? PER_W'(r_step) : PER_W'(wr_prod);

    always_comb begin
        case (i_data[1:0])
            2'd0:    nm_per = PER_W'({r_step, 5'd0});
            2'd1:    nm_per = PER_W'({r_step, 6'd0});
            2'd2:    nm_per = PER_W'({r_step, 7'd0});
            default: nm_per = {r_ntone2[PER_W-2:0], 1'b0};
        endcase
    end

    // ---------------- tone channel step ----------------
    logic                      div_start;
    logic                      div_done;
    logic [LEFT_W-1:0]         div_q;
    logic [PER_W-1:0]          div_rem;

    logic [PER_W-1:0]          t_c0;
    logic [PER_W-1:0]          t_p;
    logic                      t_old;
    logic signed [PER_W+1:0]   t_c;
    logic [LEFT_W:0]           t_qp;
    logic [PER_W:0]            t_mp;
    logic [PER_W:0]            t_acc;
    logic                      t_odd;
    logic                      t_new;
    logic [PER_W-1:0]          t_cnew;
    logic signed [OPA_W-1:0]   t_val;

    assign t_c0  = r_tcnt[r_ch];
    assign t_p   = r_tper[r_ch];
    assign t_old = r_tlvl[r_ch];
    assign t_c   = $signed({2'b00, t_c0}) - $signed((PER_W+2)'(psg_pkg::ONE_STEP));

    // wrap count m = q + 1; m*p follows from the remainder without a multiply
    assign t_qp  = {1'b0, r_negc} - (LEFT_W+1)'(div_rem);
    assign t_mp  = (PER_W+1)'(t_qp) + {1'b0, t_p};
    assign t_odd = !div_q[0];
    assign t_new = t_old ^ t_odd;
    assign t_cnew = t_p - div_rem;

    always_comb begin
        t_acc = t_odd ? (PER_W+1)'(t_qp >> 1) : (t_mp >> 1);
        if (t_new && t_odd) begin
            t_acc = t_acc + {1'b0, t_p};
        end
        t_val = (t_old ? $signed(OPA_W'(t_c0)) : '0) + $signed(OPA_W'(t_acc))
              - (t_new ? $signed(OPA_W'(t_cnew)) : '0);
    end

    assign div_start = (r_state == S_T_LOAD) && (t_c <= 0) && (t_p != '0);

    psg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (LEFT_W'(-t_c)),
        .i_divisor  (t_p),
        .o_done     (div_done),
        .o_quot     (div_q),
        .o_rem      (div_rem)
    );

    // ---------------- noise walk ----------------
    logic [LEFT_W-1:0]          n_ne;
    logic [PER_W-1:0]           n_cnt1;
    logic [psg_pkg::FB_W-1:0]   n_lfsr_x;
    logic [psg_pkg::LFSR_W-1:0] n_lfsr1;
    logic [LEFT_W-1:0]          n_left1;

    assign n_ne     = (r_ncnt < PER_W'(r_left)) ? LEFT_W'(r_ncnt) : r_left;
    assign n_cnt1   = r_ncnt - PER_W'(n_ne);
    assign n_lfsr_x = r_lfsr[0] ? ({1'b0, r_lfsr} ^ r_fb) : {1'b0, r_lfsr};
    assign n_lfsr1  = n_lfsr_x[psg_pkg::FB_W-1:1];
    assign n_left1  = r_left - n_ne;

    // ---------------- shared multiplier ----------------
    logic signed [OPA_W-1:0]  mul_a;
    logic signed [OPB_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_p;

    always_comb begin
        case (r_state)
            S_T_MUL: begin
                mul_a = r_val;
                mul_b = $signed(OPB_W'(r_tgain[r_ch]));
            end
            S_N_MUL: begin
                mul_a = $signed(OPA_W'(r_vol));
                mul_b = $signed(OPB_W'(r_ngain));
            end
            S_D_LO: begin
                mul_a = $signed(OPA_W'(r_yprev[19:0]));
                mul_b = $signed(OPB_W'(r_pole));
            end
            S_D_HI: begin
                mul_a = OPA_W'($signed(r_yprev[Y_W-1:20]));
                mul_b = $signed(OPB_W'(r_pole));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    psg_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_p)
    );

    // ---------------- mixing and DC blocker ----------------
    logic [14:0]              n_x15;
    logic [15:0]              mix_x;
    logic signed [57:0]       d_tot;
    logic signed [41:0]       d_fb;
    logic signed [16:0]       d_dx;
    logic signed [43:0]       d_y44;
    logic signed [Y_W-1:0]    d_y;
    logic [41:0]              d_mag;
    logic [25:0]              d_rnd;
    logic [15:0]              d_sample;

    assign n_x15 = psg_pkg::clamp_sum(SUM_W'(mul_p));
    assign mix_x = ({1'b0, r_tone_x} + {1'b0, n_x15}) >> 1;

    always_comb begin
        d_tot = ($signed({{(58-PROD_W){mul_p[PROD_W-1]}}, mul_p}) <<< 20)
              + $signed({{(58-PROD_W){r_plo[PROD_W-1]}}, r_plo})
              + 58'sd32768;
        d_fb  = 42'(d_tot >>> 16);
        d_dx  = $signed({1'b0, r_x}) - $signed({1'b0, r_xprev});
        d_y44 = $signed({{11{d_dx[16]}}, d_dx, 16'd0}) + $signed({{2{d_fb[41]}}, d_fb});
        if (d_y44 > $signed(44'sh07F_FFFF_FFFF)) begin
            d_y = {1'b0, {(Y_W-1){1'b1}}};
        end else if (d_y44 < -$signed(44'sh080_0000_0000)) begin
            d_y = {1'b1, {(Y_W-1){1'b0}}};
        end else begin
            d_y = Y_W'(d_y44);
        end
        // round half away from zero
        d_mag = d_y[Y_W-1] ? 42'(-$signed({{2{d_y[Y_W-1]}}, d_y}))
                           : 42'($signed({{2{d_y[Y_W-1]}}, d_y}));
        d_rnd = 26'((d_mag + 42'd32768) >> 16);
        if (!d_y[Y_W-1]) begin
            d_sample = (d_rnd > 26'd32767) ? 16'h7fff : d_rnd[15:0];
        end else begin
            d_sample = (d_rnd > 26'd32768) ? 16'h8000 : 16'(-d_rnd[15:0]);
        end
    end

    // ---------------- state and registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= psg_pkg::UPDATE_STEP_RST;
            r_pole  <= psg_pkg::DC_POLE_RST;
            for (int p = 0; p < 2; p++) begin
                r_latch[p] <= '0;
                for (int k = 0; k < 3; k++) begin
                    r_freq[p][k] <= '0;
                end
            end
            r_nmode <= '0;
            for (int k = 0; k < TONE_CHANNELS; k++) begin
                r_tper[k]  <= PER_W'(psg_pkg::UPDATE_STEP_RST);
                r_tcnt[k]  <= PER_W'(psg_pkg::UPDATE_STEP_RST);
                r_tlvl[k]  <= 1'b0;
                r_tgain[k] <= '0;
            end
            r_ntone2 <= PER_W'(psg_pkg::UPDATE_STEP_RST);
            r_nper   <= PER_W'(psg_pkg::UPDATE_STEP_RST);
            r_ncnt   <= PER_W'(psg_pkg::UPDATE_STEP_RST);
            r_lfsr   <= '0;
            r_fb     <= '0;
            r_nlvl   <= 1'b0;
            r_ngain  <= '0;
            r_xprev  <= '0;
            r_yprev  <= '0;
            r_ch     <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == psg_pkg::CFG_UPDATE_STEP) begin
                    r_step <= i_cfg_data;
                end else begin
                    r_pole <= i_cfg_data;
                end
            end

            if (r_valid && !i_stall && (r_state != S_OUT)) begin
                r_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_mode == psg_pkg::MODE_TICK)) begin
                        r_ch    <= '0;
                        r_sum   <= '0;
                        r_state <= S_T_LOAD;
                    end else if (in_acc && ((i_mode == psg_pkg::MODE_TONE)
                                         || (i_mode == psg_pkg::MODE_NOISE))) begin
                        if (wr_latch) begin
                            r_latch[wr_port] <= wr_r;
                        end
                        if (wr_is_freq) begin
                            r_freq[wr_port][wr_fi] <= wr_new;
                            if (!wr_port) begin
                                if (32'(wr_fi) < TONE_CHANNELS) begin
                                    r_tper[wr_fi[CH_W-1:0]] <= wr_per;
                                end
                            end else if (wr_fi == 2'd2) begin
                                r_ntone2 <= wr_per;
                                if (r_nmode == 2'd3) begin
                                    r_nper <= {wr_per[PER_W-2:0], 1'b0};
                                end
                            end
                        end else if (wr_latch && (wr_r == 3'd6)) begin
                            if (wr_port) begin
                                r_nmode <= i_data[1:0];
                                r_fb    <= i_data[2] ? psg_pkg::FB_WHITE
                                                     : psg_pkg::FB_PERIODIC;
                                r_nper  <= nm_per;
                                r_lfsr  <= psg_pkg::LFSR_PRESET;
                                r_nlvl  <= psg_pkg::LFSR_PRESET[0];
                            end
                        end else if (wr_latch) begin
                            if (!wr_port && (32'(wr_fi) < TONE_CHANNELS)) begin
                                r_tgain[wr_fi[CH_W-1:0]] <= psg_pkg::vol_gain(i_data[3:0]);
                            end else if (wr_port && (wr_fi == 2'd3)) begin
                                r_ngain <= psg_pkg::vol_gain(i_data[3:0]);
                            end
                        end
                    end
                end
                S_T_LOAD: begin
                    r_negc <= LEFT_W'(-t_c);
                    if (t_c > 0) begin
                        r_tcnt[r_ch] <= PER_W'(t_c);
                        r_val        <= t_old ? $signed(OPA_W'(psg_pkg::ONE_STEP)) : '0;
                        r_state      <= S_T_MUL;
                    end else if (t_p == '0) begin
                        // stuck channel: count stops at zero, level holds
                        r_tcnt[r_ch] <= '0;
                        r_val        <= t_old ? $signed(OPA_W'(t_c0)) : '0;
                        r_state      <= S_T_MUL;
                    end else begin
                        r_state <= S_T_DIV;
                    end
                end
                S_T_DIV: begin
                    if (div_done) begin
                        r_tcnt[r_ch] <= t_cnew;
                        r_tlvl[r_ch] <= t_new;
                        r_val        <= t_val;
                        r_state      <= S_T_MUL;
                    end
                end
                S_T_MUL: begin
                    r_state <= S_T_ACC;
                end
                S_T_ACC: begin
                    if (32'(r_ch) == TONE_CHANNELS - 1) begin
                        r_tone_x <= psg_pkg::clamp_sum(r_sum + SUM_W'(mul_p));
                        r_state  <= S_N_INIT;
                    end else begin
                        r_sum   <= r_sum + SUM_W'(mul_p);
                        r_ch    <= r_ch + 1'b1;
                        r_state <= S_T_LOAD;
                    end
                end
                S_N_INIT: begin
                    r_left <= psg_pkg::ONE_STEP;
                    if (r_ngain == '0) begin
                        r_vol   <= '0;
                        r_state <= S_N_MUL;
                    end else if (r_nper == '0) begin
                        r_vol   <= r_nlvl ? psg_pkg::ONE_STEP : '0;
                        r_state <= S_N_MUL;
                    end else begin
                        r_vol   <= '0;
                        r_state <= S_N_RUN;
                    end
                end
                S_N_RUN: begin
                    if (r_nlvl) begin
                        r_vol <= r_vol + n_ne;
                    end
                    if (n_cnt1 == '0) begin
                        r_lfsr <= n_lfsr1;
                        r_nlvl <= n_lfsr1[0];
                        r_ncnt <= r_nper;
                    end else begin
                        r_ncnt <= n_cnt1;
                    end
                    r_left <= n_left1;
                    if (n_left1 == '0) begin
                        r_state <= S_N_MUL;
                    end
                end
                S_N_MUL: begin
                    r_state <= S_N_ACC;
                end
                S_N_ACC: begin
                    r_x     <= mix_x;
                    r_state <= S_D_LO;
                end
                S_D_LO: begin
                    r_state <= S_D_HI;
                end
                S_D_HI: begin
                    r_plo   <= mul_p;
                    r_state <= S_D_FIN;
                end
                S_D_FIN: begin
                    r_xprev <= r_x;
                    r_yprev <= d_y;
                    r_hold  <= d_sample;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold the sample until the output register is free
                    if (!r_valid || !i_stall) begin
                        r_valid  <= 1'b1;
                        r_sample <= $signed(r_hold);
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_sample = r_sample;

endmodule

// ===== design/psg_div.sv =====
module psg_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [psg_pkg::LEFT_W-1:0]  i_dividend,
    input  logic [psg_pkg::PER_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [psg_pkg::LEFT_W-1:0]  o_quot,
    output logic [psg_pkg::PER_W-1:0]   o_rem
);

    localparam int CNT_W = $clog2(psg_pkg::LEFT_W + 1);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [psg_pkg::LEFT_W-1:0]  r_dvd;
    logic [psg_pkg::LEFT_W-1:0]  r_quot;
    logic [psg_pkg::PER_W-1:0]   r_rem;
    logic [psg_pkg::PER_W-1:0]   r_dvs;
    logic [psg_pkg::PER_W:0]     trial;
    logic                        fits;

    assign trial = {r_rem, r_dvd[psg_pkg::LEFT_W-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(psg_pkg::LEFT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd  <= i_dividend;
            r_dvs  <= i_divisor;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_dvd  <= {r_dvd[psg_pkg::LEFT_W-2:0], 1'b0};
            r_quot <= {r_quot[psg_pkg::LEFT_W-2:0], fits};
            r_rem  <= fits ? psg_pkg::PER_W'(trial - {1'b0, r_dvs})
                           : psg_pkg::PER_W'(trial);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// ===== design/psg_mul.sv =====
module psg_mul (
    input  logic                              i_clk,
    input  logic signed [psg_pkg::OPA_W-1:0]  i_a,
    input  logic signed [psg_pkg::OPB_W-1:0]  i_b,
    output logic signed [psg_pkg::PROD_W-1:0] o_prod
);

    logic signed [psg_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule
